// File: hw/rtl/aes_gcm_authenticated_cipher_unit_macros.svh
// ----------------------------------------------------------------------------
// AES-GCM unit assertion macros
// Concurrent assertion helpers that are empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef AES_GCM_AUTHENTICATED_CIPHER_UNIT_MACROS_SVH
`define AES_GCM_AUTHENTICATED_CIPHER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define AGCU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`define AGCU_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);
`else
`define AGCU_ASSERT(lbl, prop, msg)
`define AGCU_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: hw/rtl/agcu_pkg.sv
// ----------------------------------------------------------------------------
// AES-GCM unit package
// Shared item and result types, register indexes and AES/GCM helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package agcu_pkg;

  localparam int BlockBytes = 16;
  localparam logic [7:0] GfPoly = 8'he1;
  localparam logic [7:0] RcPoly = 8'h1b;
  localparam int IvDirectBytes = 12;

  typedef enum logic [2:0] {
    OP_START  = 3'd0,
    OP_IV     = 3'd1,
    OP_AAD    = 3'd2,
    OP_TEXT   = 3'd3,
    OP_FINISH = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    RK_TEXT    = 2'd0,
    RK_TAG     = 2'd1,
    RK_VERDICT = 2'd2
  } rkind_e;

  typedef enum logic [2:0] {
    REG_KEY0     = 3'd0,
    REG_KEY1     = 3'd1,
    REG_KEY2     = 3'd2,
    REG_KEY3     = 3'd3,
    REG_KEY_SIZE = 3'd4,
    REG_TAG      = 3'd5
  } reg_e;

  typedef struct packed {
    op_e          op;
    logic         decrypt;
    logic [127:0] data;
    logic [4:0]   nbytes;
  } item_t;

  typedef struct packed {
    rkind_e       kind;
    logic [127:0] data;
    logic [4:0]   nbytes;
    logic         match;
  } result_t;

  typedef struct packed {
    logic kexp;
    logic enc;
  } aes_req_t;

  localparam logic [0:255][7:0] SBOX = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  function automatic logic [7:0] xt(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? RcPoly : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0]   a [16];
    logic [7:0]   t [16];
    logic [7:0]   x, a0, a1, a2, a3;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) a[i] = s[127 - 8 * i -: 8];
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++) t[c * 4 + i] = SBOX[a[((c + i) & 3) * 4 + i]];
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[c * 4];
        a1 = t[c * 4 + 1];
        a2 = t[c * 4 + 2];
        a3 = t[c * 4 + 3];
        x = a0 ^ a1 ^ a2 ^ a3;
        t[c * 4]     = a0 ^ x ^ xt(a0 ^ a1);
        t[c * 4 + 1] = a1 ^ x ^ xt(a1 ^ a2);
        t[c * 4 + 2] = a2 ^ x ^ xt(a2 ^ a3);
        t[c * 4 + 3] = a3 ^ x ^ xt(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = t[i];
    return r;
  endfunction

  function automatic logic [127:0] lead_mask(input logic [4:0] n);
    logic [127:0] m;
    for (int b = 0; b < BlockBytes; b++) m[127 - 8 * b -: 8] = (5'(b) < n) ? 8'hff : 8'h00;
    return m;
  endfunction

  function automatic logic [127:0] inc32(input logic [127:0] v);
    return {v[127:32], v[31:0] + 32'd1};
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/agcu_front.sv
// ----------------------------------------------------------------------------
// AES-GCM unit front end
// Accepts input transfers, drops items that cannot act, masks short blocks
// and queues the rest for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module agcu_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           s_valid_i,
  output logic                s_ready_o,
  input  wire logic [2:0]     s_op_i,
  input  wire logic           s_dec_i,
  input  wire logic [127:0]   s_block_i,
  input  wire logic [4:0]     s_count_i,
  output logic                item_valid_o,
  input  wire logic           item_ready_i,
  output agcu_pkg::item_t     item_o
);

  agcu_pkg::item_t fifo_q [2];
  agcu_pkg::item_t cls;
  logic            wptr_q, rptr_q;
  logic [1:0]      cnt_q;
  logic            keep, push, pop;
  logic [4:0]      nsat;

  always_comb begin
    nsat = (s_count_i > 5'd16) ? 5'd16 : s_count_i;
    cls.op = agcu_pkg::op_e'(s_op_i);
    cls.decrypt = s_dec_i;
    cls.nbytes = nsat;
    cls.data = s_block_i;
    keep = 1'b0;
    case (s_op_i) inside
      agcu_pkg::OP_START, agcu_pkg::OP_FINISH: keep = 1'b1;
      agcu_pkg::OP_IV, agcu_pkg::OP_AAD, agcu_pkg::OP_TEXT: begin
        keep = (s_count_i != 5'd0);
        cls.data = s_block_i & agcu_pkg::lead_mask(nsat);
      end
      default: keep = 1'b0;
    endcase
  end

  assign s_ready_o    = (cnt_q != 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = fifo_q[rptr_q];
  assign push         = s_valid_i && s_ready_o && keep;
  assign pop          = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wptr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/agcu_aes.sv
// ----------------------------------------------------------------------------
// AES-GCM unit cipher core
// Key expansion one word per cycle into a round key memory, and block
// encryption one round per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module agcu_aes #(
  parameter int MAX_ROUNDS = 14
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire agcu_pkg::aes_req_t req_i,
  input  wire logic [255:0]       key_i,
  input  wire logic [1:0]         key_size_i,
  input  wire logic [127:0]       block_i,
  output logic                    done_o,
  output logic [127:0]            block_o
);

  localparam int RkAw = $clog2(MAX_ROUNDS + 1);
  localparam int WiW  = RkAw + 2;

  typedef enum logic [2:0] {
    AS_IDLE = 3'b001,
    AS_KEXP = 3'b010,
    AS_RUN  = 3'b100
  } ast_e;

  ast_e             st_q;
  logic [127:0]     rk_mem [MAX_ROUNDS + 1];
  logic [127:0]     rk_q, s_q;
  logic [RkAw-1:0]  rd_addr;
  logic [3:0]       nk_c, nk_q, nr_q, round_q;
  logic [WiW-1:0]   widx_q;
  logic [2:0]       kmod_q;
  logic [7:0]       rc_q;
  logic [31:0]      kwin_q [8];
  logic [31:0]      t, wold, wnew, kw_key;
  logic             is_key, kexp_last, done_q;

  always_comb begin
    case (key_size_i)
      2'd0:    nk_c = 4'd4;
      2'd1:    nk_c = 4'd6;
      default: nk_c = 4'd8;
    endcase
    if (int'(nk_c) + 6 > MAX_ROUNDS) nk_c = nk_c - 4'd2;
    if (int'(nk_c) + 6 > MAX_ROUNDS) nk_c = nk_c - 4'd2;
  end

  always_comb begin
    kw_key = key_i[255 - 32 * widx_q[2:0] -: 32];
    is_key = (widx_q < WiW'(nk_q));
    t = kwin_q[7];
    if (kmod_q == 3'd0) begin
      t = agcu_pkg::sub_word({t[23:0], t[31:24]}) ^ {rc_q, 24'd0};
    end else if (nk_q == 4'd8 && kmod_q == 3'd4) begin
      t = agcu_pkg::sub_word(t);
    end
    case (nk_q)
      4'd4:    wold = kwin_q[4];
      4'd6:    wold = kwin_q[2];
      default: wold = kwin_q[0];
    endcase
    wnew = is_key ? kw_key : (wold ^ t);
    kexp_last = (widx_q == {RkAw'(nr_q), 2'b11});
  end

  always_comb begin
    rd_addr = '0;
    if (st_q == AS_RUN && round_q != nr_q) rd_addr = RkAw'(round_q + 4'd1);
  end

  always_ff @(posedge clk_i) begin
    if (st_q == AS_KEXP && widx_q[1:0] == 2'b11)
      rk_mem[widx_q[WiW-1:2]] <= {kwin_q[5], kwin_q[6], kwin_q[7], wnew};
    rk_q <= rk_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (st_q == AS_KEXP) begin
      for (int j = 0; j < 7; j++) kwin_q[j] <= kwin_q[j + 1];
      kwin_q[7] <= wnew;
    end
    if (st_q == AS_IDLE && req_i.enc) begin
      s_q <= block_i;
    end else if (st_q == AS_RUN) begin
      if (round_q == 4'd0) s_q <= s_q ^ rk_q;
      else s_q <= agcu_pkg::aes_round(s_q, round_q == nr_q) ^ rk_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= AS_IDLE;
      done_q  <= 1'b0;
      nk_q    <= 4'd4;
      nr_q    <= 4'd10;
      round_q <= 4'd0;
      widx_q  <= '0;
      kmod_q  <= 3'd0;
      rc_q    <= 8'h01;
    end else begin
      done_q <= 1'b0;
      unique case (st_q)
        AS_IDLE: begin
          if (req_i.kexp) begin
            nk_q   <= nk_c;
            nr_q   <= nk_c + 4'd6;
            widx_q <= '0;
            kmod_q <= 3'd0;
            rc_q   <= 8'h01;
            st_q   <= AS_KEXP;
          end else if (req_i.enc) begin
            round_q <= 4'd0;
            st_q    <= AS_RUN;
          end
        end
        AS_KEXP: begin
          kmod_q <= ({1'b0, kmod_q} + 4'd1 == nk_q) ? 3'd0 : kmod_q + 3'd1;
          if (!is_key && kmod_q == 3'd0) rc_q <= agcu_pkg::xt(rc_q);
          widx_q <= widx_q + WiW'(1);
          if (kexp_last) begin
            st_q   <= AS_IDLE;
            done_q <= 1'b1;
          end
        end
        AS_RUN: begin
          round_q <= round_q + 4'd1;
          if (round_q == nr_q) begin
            st_q   <= AS_IDLE;
            done_q <= 1'b1;
          end
        end
        default: st_q <= AS_IDLE;
      endcase
    end
  end

  assign done_o  = done_q;
  assign block_o = s_q;

endmodule

`default_nettype wire

// File: hw/rtl/agcu_ghash.sv
// ----------------------------------------------------------------------------
// AES-GCM unit GHASH multiplier
// GF(2^128) multiply by the hash key, eight bits of the operand per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module agcu_ghash (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [127:0] x_i,
  input  wire logic [127:0] h_i,
  output logic              done_o,
  output logic [127:0]      z_o
);

  logic [127:0] a_q, z_q, v_q, z_n, v_n;
  logic [3:0]   cnt_q;
  logic         busy_q, done_q;

  always_comb begin
    z_n = z_q;
    v_n = v_q;
    for (int k = 0; k < 8; k++) begin
      if (a_q[127 - k]) z_n = z_n ^ v_n;
      v_n = {1'b0, v_n[127:1]} ^ (v_n[0] ? {agcu_pkg::GfPoly, 120'd0} : 128'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= x_i;
      z_q <= '0;
      v_q <= h_i;
    end else if (busy_q) begin
      a_q <= {a_q[119:0], 8'd0};
      z_q <= z_n;
      v_q <= v_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 4'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 4'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign z_o    = z_q;

endmodule

`default_nettype wire

// File: hw/rtl/agcu_back.sv
// ----------------------------------------------------------------------------
// AES-GCM unit back end
// Sequences key setup, J0, keystream, GHASH and tag work for each item.
// ----------------------------------------------------------------------------
`default_nettype none
`include "aes_gcm_authenticated_cipher_unit_macros.svh"

module agcu_back #(
  parameter int MAX_ROUNDS  = 14,
  parameter int LENGTH_BITS = 61
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            item_valid_i,
  output logic                 item_ready_o,
  input  wire agcu_pkg::item_t item_i,
  input  wire logic [255:0]    key_i,
  input  wire logic [1:0]      key_size_i,
  input  wire logic [4:0]      tag_bytes_i,
  output logic                 res_valid_o,
  input  wire logic            res_ready_i,
  output agcu_pkg::result_t    res_o
);

  typedef enum logic [9:0] {
    C_IDLE = 10'b0000000001,
    C_DISP = 10'b0000000010,
    C_KEXP = 10'b0000000100,
    C_HKEY = 10'b0000001000,
    C_J0   = 10'b0000010000,
    C_MASK = 10'b0000100000,
    C_BODY = 10'b0001000000,
    C_KS   = 10'b0010000000,
    C_GHD  = 10'b0100000000,
    C_OUT  = 10'b1000000000
  } cst_e;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_IV   = 4'b0010,
    PH_AAD  = 4'b0100,
    PH_TEXT = 4'b1000
  } phase_e;

  cst_e                   st_q, st_d;
  phase_e                 phase_q, phase_d;
  agcu_pkg::item_t        cur_q, cur_d;
  agcu_pkg::result_t      res_q, res_d;
  logic                   dec_q, dec_d;
  logic [127:0]           hkey_q, hkey_d, ctr_q, ctr_d, mask_q, mask_d, acc_q, acc_d;
  logic [95:0]            head_q, head_d;
  logic [LENGTH_BITS-1:0] ivlen_q, ivlen_d, aad_q, aad_d, txt_q, txt_d, nlen;
  agcu_pkg::aes_req_t     aes_req;
  logic [127:0]           aes_in, aes_out, gh_x, gh_z, tag, tmask, ctext;
  logic                   aes_done, gh_start, gh_done;
  logic [4:0]             tb;

  agcu_aes #(.MAX_ROUNDS(MAX_ROUNDS)) u_aes (
    .clk_i, .rst_ni,
    .req_i      (aes_req),
    .key_i      (key_i),
    .key_size_i (key_size_i),
    .block_i    (aes_in),
    .done_o     (aes_done),
    .block_o    (aes_out)
  );

  agcu_ghash u_ghash (
    .clk_i, .rst_ni,
    .start_i (gh_start),
    .x_i     (gh_x),
    .h_i     (hkey_q),
    .done_o  (gh_done),
    .z_o     (gh_z)
  );

  always_comb begin
    tb = (tag_bytes_i == 5'd0) ? 5'd1 : ((tag_bytes_i > 5'd16) ? 5'd16 : tag_bytes_i);
    tmask = agcu_pkg::lead_mask(tb);
    tag = mask_q ^ gh_z;
    ctext = (cur_q.data ^ aes_out) & agcu_pkg::lead_mask(cur_q.nbytes);
    nlen = LENGTH_BITS'(cur_q.nbytes);
  end

  always_comb begin
    st_d = st_q;
    phase_d = phase_q;
    cur_d = cur_q;
    res_d = res_q;
    dec_d = dec_q;
    hkey_d = hkey_q;
    ctr_d = ctr_q;
    mask_d = mask_q;
    acc_d = acc_q;
    head_d = head_q;
    ivlen_d = ivlen_q;
    aad_d = aad_q;
    txt_d = txt_q;
    aes_req = '0;
    aes_in = ctr_q;
    gh_start = 1'b0;
    gh_x = acc_q ^ cur_q.data;
    unique case (st_q)
      C_IDLE: begin
        if (item_valid_i) begin
          cur_d = item_i;
          st_d = C_DISP;
        end
      end
      C_DISP: begin
        if (cur_q.op == agcu_pkg::OP_START) begin
          dec_d = cur_q.decrypt;
          acc_d = '0;
          ctr_d = '0;
          mask_d = '0;
          head_d = '0;
          ivlen_d = '0;
          aad_d = '0;
          txt_d = '0;
          aes_req.kexp = 1'b1;
          st_d = C_KEXP;
        end else if (phase_q == PH_IDLE) begin
          st_d = C_IDLE;
        end else if (cur_q.op == agcu_pkg::OP_IV) begin
          if (phase_q != PH_IV) begin
            st_d = C_IDLE;
          end else begin
            if (ivlen_q == '0) head_d = cur_q.data[127:32];
            gh_start = 1'b1;
            st_d = C_GHD;
          end
        end else if (cur_q.op == agcu_pkg::OP_AAD && phase_q == PH_TEXT) begin
          st_d = C_IDLE;
        end else if (phase_q == PH_IV) begin
          if (ivlen_q == LENGTH_BITS'(agcu_pkg::IvDirectBytes)) begin
            aes_in = {head_q, 32'd1};
            aes_req.enc = 1'b1;
            ctr_d = agcu_pkg::inc32({head_q, 32'd1});
            acc_d = '0;
            st_d = C_MASK;
          end else begin
            gh_x = acc_q ^ {64'd0, 64'({ivlen_q, 3'b000})};
            gh_start = 1'b1;
            st_d = C_J0;
          end
        end else begin
          st_d = C_BODY;
        end
      end
      C_KEXP: begin
        if (aes_done) begin
          aes_in = '0;
          aes_req.enc = 1'b1;
          st_d = C_HKEY;
        end
      end
      C_HKEY: begin
        if (aes_done) begin
          hkey_d = aes_out;
          phase_d = PH_IV;
          st_d = C_IDLE;
        end
      end
      C_J0: begin
        if (gh_done) begin
          acc_d = '0;
          ctr_d = agcu_pkg::inc32(gh_z);
          aes_in = gh_z;
          aes_req.enc = 1'b1;
          st_d = C_MASK;
        end
      end
      C_MASK: begin
        if (aes_done) begin
          mask_d = aes_out;
          phase_d = PH_AAD;
          st_d = C_BODY;
        end
      end
      C_BODY: begin
        case (cur_q.op)
          agcu_pkg::OP_AAD: begin
            gh_start = 1'b1;
            st_d = C_GHD;
          end
          agcu_pkg::OP_TEXT: begin
            phase_d = PH_TEXT;
            aes_in = ctr_q;
            aes_req.enc = 1'b1;
            ctr_d = agcu_pkg::inc32(ctr_q);
            st_d = C_KS;
          end
          agcu_pkg::OP_FINISH: begin
            gh_x = acc_q ^ {64'({aad_q, 3'b000}), 64'({txt_q, 3'b000})};
            gh_start = 1'b1;
            st_d = C_GHD;
          end
          default: st_d = C_IDLE;
        endcase
      end
      C_KS: begin
        if (aes_done) begin
          res_d.data = ctext;
          gh_x = acc_q ^ (dec_q ? cur_q.data : ctext);
          gh_start = 1'b1;
          st_d = C_GHD;
        end
      end
      C_GHD: begin
        if (gh_done) begin
          acc_d = gh_z;
          st_d = C_IDLE;
          case (cur_q.op)
            agcu_pkg::OP_IV:  ivlen_d = ivlen_q + nlen;
            agcu_pkg::OP_AAD: aad_d = aad_q + nlen;
            agcu_pkg::OP_TEXT: begin
              txt_d = txt_q + nlen;
              res_d.kind = agcu_pkg::RK_TEXT;
              res_d.nbytes = cur_q.nbytes;
              res_d.match = 1'b0;
              st_d = C_OUT;
            end
            agcu_pkg::OP_FINISH: begin
              phase_d = PH_IDLE;
              if (!dec_q) begin
                res_d.kind = agcu_pkg::RK_TAG;
                res_d.data = tag & tmask;
                res_d.nbytes = tb;
                res_d.match = 1'b0;
              end else begin
                res_d.kind = agcu_pkg::RK_VERDICT;
                res_d.data = '0;
                res_d.nbytes = 5'd0;
                res_d.match = (((tag ^ cur_q.data) & tmask) == 128'd0);
              end
              st_d = C_OUT;
            end
            default: st_d = C_IDLE;
          endcase
        end
      end
      C_OUT: begin
        if (res_ready_i) st_d = C_IDLE;
      end
      default: st_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= C_IDLE;
      phase_q <= PH_IDLE;
      dec_q   <= 1'b0;
      hkey_q  <= '0;
      ctr_q   <= '0;
      mask_q  <= '0;
      acc_q   <= '0;
      head_q  <= '0;
      ivlen_q <= '0;
      aad_q   <= '0;
      txt_q   <= '0;
    end else begin
      st_q    <= st_d;
      phase_q <= phase_d;
      dec_q   <= dec_d;
      hkey_q  <= hkey_d;
      ctr_q   <= ctr_d;
      mask_q  <= mask_d;
      acc_q   <= acc_d;
      head_q  <= head_d;
      ivlen_q <= ivlen_d;
      aad_q   <= aad_d;
      txt_q   <= txt_d;
    end
  end

  assign item_ready_o = (st_q == C_IDLE);
  assign res_valid_o  = (st_q == C_OUT);
  assign res_o        = res_q;

  `AGCU_ASSERT(a_gh_done_waited, gh_done |-> (st_q == C_J0 || st_q == C_GHD), "GHASH finished while nobody waited")
  `AGCU_ASSERT(a_aes_done_waited, aes_done |-> (st_q == C_KEXP || st_q == C_HKEY || st_q == C_MASK || st_q == C_KS), "cipher finished while nobody waited")
  `AGCU_ASSERT_NEVER(a_body_after_settle, st_q == C_BODY && phase_q == PH_IV, "item body reached before J0 was settled")
  `AGCU_ASSERT(a_result_held, (res_valid_o && !res_ready_i) |=> (res_valid_o && $stable(res_q)), "pending result changed")

endmodule

`default_nettype wire

// File: hw/rtl/aes_gcm_authenticated_cipher_unit.sv
// ----------------------------------------------------------------------------
// AES-GCM authenticated cipher unit
// Usage: program key words, key size and tag length over APB while idle, then
// stream items on the slave stream: start, IV blocks, AAD blocks, text blocks
// and finish. Each text block yields one result transfer on the master
// stream; finish yields the tag (encrypt) or a verdict (decrypt).
// Start expands the key at one word per cycle and then encrypts the zero
// block. A text block takes one AES pass (Nr = 10, 12 or 14) and then a
// GHASH pass; AAD and IV blocks take the GHASH pass alone. The first block
// after the IV adds the J0 work, up to one GHASH and one AES pass.
// The block passes run on the iterated round unit and the eight-bit-per-cycle
// multiplier; items are worked one at a time.
// A two-entry queue in front and a result register at the output let input
// and output stall independently. A stalled receiver holds the result in the
// output register and the back end halts behind it.
// Reset clears the configuration to key 0, 128-bit key and a 16-byte tag, and
// returns the unit to waiting for a start item.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_gcm_authenticated_cipher_unit #(
  parameter int MAX_ROUNDS  = 14,
  parameter int LENGTH_BITS = 61
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // tdata: block_hi[63:0], block_lo[127:64], byte_count[132:128], zero pad
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [135:0] s_axis_tdata,
  // tuser: operation[2:0], decrypt[3]
  input  wire logic [3:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: data_hi[63:0], data_lo[127:64], valid_bytes[132:128], tag_match[133]
  output logic [135:0]      m_axis_tdata,
  // tuser: result_kind[1:0]
  output logic [1:0]        m_axis_tuser,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [5:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  logic [63:0]       key0_q, key1_q, key2_q, key3_q;
  logic [1:0]        ksize_q;
  logic [4:0]        tag_q;
  logic              cfg_we;
  agcu_pkg::reg_e    cfg_idx;
  logic              item_valid, item_ready, res_valid, res_ready, out_valid_q;
  agcu_pkg::item_t   item;
  agcu_pkg::result_t res, out_q;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = agcu_pkg::reg_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q  <= '0;
      key1_q  <= '0;
      key2_q  <= '0;
      key3_q  <= '0;
      ksize_q <= 2'd0;
      tag_q   <= 5'd16;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        agcu_pkg::REG_KEY0:     key0_q <= pwdata;
        agcu_pkg::REG_KEY1:     key1_q <= pwdata;
        agcu_pkg::REG_KEY2:     key2_q <= pwdata;
        agcu_pkg::REG_KEY3:     key3_q <= pwdata;
        agcu_pkg::REG_KEY_SIZE: ksize_q <= pwdata[1:0];
        agcu_pkg::REG_TAG:      tag_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      agcu_pkg::REG_KEY0:     prdata = key0_q;
      agcu_pkg::REG_KEY1:     prdata = key1_q;
      agcu_pkg::REG_KEY2:     prdata = key2_q;
      agcu_pkg::REG_KEY3:     prdata = key3_q;
      agcu_pkg::REG_KEY_SIZE: prdata = {62'd0, ksize_q};
      agcu_pkg::REG_TAG:      prdata = {59'd0, tag_q};
      default:                prdata = 64'd0;
    endcase
  end

  agcu_front u_front (
    .clk_i, .rst_ni,
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_op_i       (s_axis_tuser[2:0]),
    .s_dec_i      (s_axis_tuser[3]),
    .s_block_i    ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
    .s_count_i    (s_axis_tdata[132:128]),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  agcu_back #(.MAX_ROUNDS(MAX_ROUNDS), .LENGTH_BITS(LENGTH_BITS)) u_back (
    .clk_i, .rst_ni,
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .key_i        ({key0_q, key1_q, key2_q, key3_q}),
    .key_size_i   (ksize_q),
    .tag_bytes_i  (tag_q),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'd0, out_q.match, out_q.nbytes, out_q.data[63:0],
                          out_q.data[127:64]};
  assign m_axis_tuser  = out_q.kind;

endmodule

`default_nettype wire
